// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the median filter.
// Both macros sample on the rising edge of clk and are off while arst_n is low.
// ASSERT_IMPL checks the consequent in the same cycle as the antecedent.
// ASSERT_NEXT checks the consequent in the cycle after the antecedent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPL(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/med3_pkg.sv -----
`timescale 1ns / 1ps

package med3_pkg;

	// pixel and window geometry
	localparam int PIX_W     = 24;
	localparam int CH_W      = 8;
	localparam int NB        = 9;
	localparam int MID       = 4;
	localparam int NUM_CELLS = MID + 1;

	// field and register widths
	localparam int COL_OUT_W = 11;
	localparam int ROW_W     = 12;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;

	localparam int MAX_LINE_DEF = 2048;
	localparam int MIN_DIM      = 3;

	localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 12'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH   = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [NB-1:0] win_t;

	// emission flags and coordinates fixed when the item is accepted
	typedef struct packed {
		logic                 em_a;
		logic                 a_med;
		logic                 em_b;
		logic                 em_c;
		logic                 done;
		logic [COL_OUT_W-1:0] col_a;
		logic [COL_OUT_W-1:0] col_bc;
		logic [ROW_W-1:0]     row_ab;
		logic [ROW_W-1:0]     row_c;
	} tag_t;

	typedef struct packed {
		tag_t tag;
		pix_t a_pass;
		pix_t b_pix;
		pix_t c_pix;
	} side_t;

	typedef struct packed {
		win_t  vec;
		side_t side;
	} stage_t;

	function automatic logic [CH_W-1:0] red_of(input pix_t p);
		return p[PIX_W-1 -: CH_W];
	endfunction

endpackage

// ----- hw/rtl/med3_ram.sv -----
`timescale 1ns / 1ps

module med3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/med3_cell.sv -----
`timescale 1ns / 1ps

// One row of the exchange sort: entry ROW is compared against every later
// entry in turn and swapped when its red is larger.
module med3_cell #(
	parameter int ROW = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	input  med3_pkg::stage_t  up_data,
	output logic              up_ready,
	output logic              dn_valid,
	output med3_pkg::stage_t  dn_data,
	input  logic              dn_ready
);

	logic             valid_q;
	med3_pkg::stage_t data_q;
	med3_pkg::win_t   vec_next;
	med3_pkg::pix_t   pa;
	med3_pkg::pix_t   pb;

	// run the compare-exchange steps of this row
	always_comb begin
		vec_next = up_data.vec;
		pa = '0;
		pb = '0;
		for (int j = 0; j < med3_pkg::NB; j++) begin
			if (j > ROW) begin
				pa = vec_next[ROW];
				pb = vec_next[j];
				if (med3_pkg::red_of(pa) > med3_pkg::red_of(pb)) begin
					vec_next[ROW] = pb;
					vec_next[j] = pa;
				end
			end
		end
	end

	assign up_ready = !valid_q || dn_ready;

	// hold or advance the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q.vec <= vec_next;
			data_q.side <= up_data.side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data = data_q;

endmodule

// ----- hw/rtl/med3_out.sv -----
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Holds the up to three results of one item and hands them out one per cycle while out_stall is low.
module med3_out (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                up_valid,
	input  med3_pkg::stage_t                    up_data,
	output logic                                up_ready,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [med3_pkg::COL_OUT_W-1:0]      col_out,
	output logic [med3_pkg::ROW_W-1:0]          row_out,
	output logic [med3_pkg::CH_W-1:0]           red_out,
	output logic [med3_pkg::CH_W-1:0]           green_out,
	output logic [med3_pkg::CH_W-1:0]           blue_out,
	output logic                                frame_done
);

	logic [2:0]                         mask_q;
	logic [2:0]                         sel;
	logic                               out_fire;
	logic                               load;
	med3_pkg::pix_t                     a_pix_q;
	med3_pkg::pix_t                     b_pix_q;
	med3_pkg::pix_t                     c_pix_q;
	logic [med3_pkg::COL_OUT_W-1:0]     col_a_q;
	logic [med3_pkg::COL_OUT_W-1:0]     col_bc_q;
	logic [med3_pkg::ROW_W-1:0]         row_ab_q;
	logic [med3_pkg::ROW_W-1:0]         row_c_q;
	logic                               done_q;
	med3_pkg::pix_t                     pix_o;

	assign out_valid = |mask_q;
	assign out_fire = out_valid && !out_stall;
	// lowest pending slot goes first: median or left-border pixel, row-end pixel, border pixel
	assign sel = mask_q & (~mask_q + 3'd1);
	assign up_ready = (mask_q == 3'b000) || (out_fire && (mask_q == sel));
	assign load = up_valid && up_ready;

	// slot mask: load a new item or drop the slot just taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 3'b000;
		end else if (up_ready) begin
			mask_q <= up_valid ? {up_data.side.tag.em_c, up_data.side.tag.em_b,
				up_data.side.tag.em_a} : 3'b000;
		end else if (out_fire) begin
			mask_q <= mask_q & ~sel;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_pix_q <= up_data.side.tag.a_med ? up_data.vec[med3_pkg::MID]
				: up_data.side.a_pass;
			b_pix_q <= up_data.side.b_pix;
			c_pix_q <= up_data.side.c_pix;
			col_a_q <= up_data.side.tag.col_a;
			col_bc_q <= up_data.side.tag.col_bc;
			row_ab_q <= up_data.side.tag.row_ab;
			row_c_q <= up_data.side.tag.row_c;
			done_q <= up_data.side.tag.done;
		end
	end

	// select the pending slot onto the ports
	always_comb begin
		priority if (mask_q[0]) begin
			col_out = col_a_q;
			row_out = row_ab_q;
			pix_o = a_pix_q;
			frame_done = 1'b0;
		end else if (mask_q[1]) begin
			col_out = col_bc_q;
			row_out = row_ab_q;
			pix_o = b_pix_q;
			frame_done = 1'b0;
		end else begin
			col_out = col_bc_q;
			row_out = row_c_q;
			pix_o = c_pix_q;
			frame_done = done_q;
		end
	end

	assign red_out = pix_o[23:16];
	assign green_out = pix_o[15:8];
	assign blue_out = pix_o[7:0];

	`ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, mask_q == $past(mask_q), "slot mask changed while output stalled")
	`ASSERT_NEXT(a_drain_one, out_fire && !up_valid, $countones(mask_q) == $countones($past(mask_q)) - 1, "taken result did not drop exactly one slot")
	`ASSERT_IMPL(a_frame_done_slot, out_valid && frame_done, !mask_q[0] && !mask_q[1], "frame_done shown on a non-border slot")

endmodule

// ----- hw/rtl/median3x3_red_keyed_filter.sv -----
`timescale 1ns / 1ps

`include "assert_macros.svh"

// 3x3 median filter keyed on red over an RGB888 raster stream. Pixels are
// taken one per clock while in_stall is low; each interior pixel is replaced
// by the middle entry of its neighborhood ordered by red (green and blue follow
// red), and border pixels pass through, every result tagged with its column and
// row. The line buffers (two RAMs of MAX_LINE entries, one read and one write
// per cycle) and a chain of five sort cells run at one pixel per cycle when
// nothing stalls. Results leave one per cycle while out_stall is low, so an
// input that yields two or three results (each pixel of the last row but the
// first, the last pixel of rows two onward) holds the input channel while its
// extra results drain. The line buffers are not cleared after reset;
// line_width and frame_height are to be written only while idle; the block
// itself does not enforce this.
module median3x3_red_keyed_filter #(
	parameter int MAX_LINE = med3_pkg::MAX_LINE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [med3_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [med3_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [med3_pkg::CH_W-1:0]           red_in,
	input  logic [med3_pkg::CH_W-1:0]           green_in,
	input  logic [med3_pkg::CH_W-1:0]           blue_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [med3_pkg::COL_OUT_W-1:0]      col_out,
	output logic [med3_pkg::ROW_W-1:0]          row_out,
	output logic [med3_pkg::CH_W-1:0]           red_out,
	output logic [med3_pkg::CH_W-1:0]           green_out,
	output logic [med3_pkg::CH_W-1:0]           blue_out,
	output logic                                frame_done
);

	localparam int CW   = $clog2(MAX_LINE);
	localparam int MLW  = $clog2(MAX_LINE + 1);
	localparam int LW_W = (med3_pkg::CFG_W > MLW) ? med3_pkg::CFG_W : MLW;
	localparam int RW   = med3_pkg::ROW_W;
	localparam int NC   = med3_pkg::NUM_CELLS;

	// configuration registers
	logic [med3_pkg::CFG_W-1:0] line_width_q;
	logic [med3_pkg::CFG_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= med3_pkg::LINE_WIDTH_RST;
			frame_height_q <= med3_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (med3_pkg::cfg_reg_t'(cfg_index))
				med3_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data;
				med3_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [LW_W-1:0]  lw_ext;
	logic [LW_W-1:0]  w_eff;
	logic [LW_W-1:0]  wlast;
	logic [RW-1:0]    h_eff;
	logic [RW-1:0]    hlast;

	always_comb begin
		lw_ext = LW_W'(line_width_q);
		if (lw_ext < LW_W'(med3_pkg::MIN_DIM)) begin
			w_eff = LW_W'(med3_pkg::MIN_DIM);
		end else if (lw_ext > LW_W'(MAX_LINE)) begin
			w_eff = LW_W'(MAX_LINE);
		end else begin
			w_eff = lw_ext;
		end
		h_eff = (frame_height_q < RW'(med3_pkg::MIN_DIM)) ? RW'(med3_pkg::MIN_DIM)
			: frame_height_q;
		wlast = w_eff - LW_W'(1);
		hlast = h_eff - RW'(1);
	end

	// raster position of the incoming pixel
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [LW_W-1:0]  x_ext;
	logic [CW-1:0]    x_acc;
	logic [RW-1:0]    y_acc;
	logic             x_last;
	logic             y_last;
	logic             in_fire;
	logic             s1_load;
	med3_pkg::tag_t   tag_acc;
	med3_pkg::pix_t   pix_acc;

	always_comb begin
		x_ext = (LW_W'(col_q) > wlast) ? wlast : LW_W'(col_q);
		x_acc = CW'(x_ext);
		y_acc = (row_q > hlast) ? hlast : row_q;
		x_last = (x_ext == wlast);
		y_last = (y_acc == hlast);
		pix_acc = {red_in, green_in, blue_in};
		tag_acc.em_a = (y_acc >= RW'(2)) && (x_ext >= LW_W'(1));
		tag_acc.a_med = (x_ext >= LW_W'(2));
		tag_acc.em_b = (y_acc >= RW'(2)) && x_last;
		tag_acc.em_c = (y_acc == '0) || y_last;
		tag_acc.done = x_last && y_last;
		tag_acc.col_a = med3_pkg::COL_OUT_W'(x_acc - CW'(1));
		tag_acc.col_bc = med3_pkg::COL_OUT_W'(x_acc);
		tag_acc.row_ab = y_acc - RW'(1);
		tag_acc.row_c = y_acc;
	end

	assign in_stall = !s1_load;
	assign in_fire = in_valid && s1_load;

	// advance the raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (x_last) begin
				col_q <= '0;
				row_q <= y_last ? '0 : y_acc + RW'(1);
			end else begin
				col_q <= x_acc + CW'(1);
				row_q <= y_acc;
			end
		end
	end

	// stage 1: accepted pixel, line buffer reads arrive alongside
	logic             valid_s1;
	med3_pkg::pix_t   pix_s1;
	logic [CW-1:0]    x_s1;
	med3_pkg::tag_t   tag_s1;
	med3_pkg::pix_t   up2;
	med3_pkg::pix_t   up1;
	logic             s1_move;
	med3_pkg::pix_t   win_q [6];

	logic [NC:0]      cell_valid;
	logic [NC:0]      cell_ready;
	med3_pkg::stage_t cell_data [NC+1];

	assign s1_load = !valid_s1 || cell_ready[0];
	assign s1_move = valid_s1 && cell_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1 <= pix_acc;
			x_s1 <= x_acc;
			tag_s1 <= tag_acc;
		end
	end

	med3_ram #(
		.WIDTH(med3_pkg::PIX_W),
		.DEPTH(MAX_LINE)
	) u_older_line (
		.clk   (clk),
		.we    (s1_move),
		.waddr (x_s1),
		.wdata (up1),
		.re    (in_fire),
		.raddr (x_acc),
		.rdata (up2)
	);

	med3_ram #(
		.WIDTH(med3_pkg::PIX_W),
		.DEPTH(MAX_LINE)
	) u_newer_line (
		.clk   (clk),
		.we    (s1_move),
		.waddr (x_s1),
		.wdata (pix_s1),
		.re    (in_fire),
		.raddr (x_acc),
		.rdata (up1)
	);

	// shift the window as the item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_move) begin
			win_q[0] <= win_q[1];
			win_q[1] <= up2;
			win_q[2] <= win_q[3];
			win_q[3] <= up1;
			win_q[4] <= win_q[5];
			win_q[5] <= pix_s1;
		end
	end

	// gather the neighborhood in row-major order
	always_comb begin
		cell_data[0].vec[0] = win_q[0];
		cell_data[0].vec[1] = win_q[1];
		cell_data[0].vec[2] = up2;
		cell_data[0].vec[3] = win_q[2];
		cell_data[0].vec[4] = win_q[3];
		cell_data[0].vec[5] = up1;
		cell_data[0].vec[6] = win_q[4];
		cell_data[0].vec[7] = win_q[5];
		cell_data[0].vec[8] = pix_s1;
		cell_data[0].side.tag = tag_s1;
		cell_data[0].side.a_pass = win_q[3];
		cell_data[0].side.b_pix = up1;
		cell_data[0].side.c_pix = pix_s1;
	end

	assign cell_valid[0] = valid_s1;

	// sort chain: cell k settles entry k
	for (genvar k = 0; k < NC; k++) begin : g_cell
		med3_cell #(
			.ROW(k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cell_valid[k]),
			.up_data  (cell_data[k]),
			.up_ready (cell_ready[k]),
			.dn_valid (cell_valid[k+1]),
			.dn_data  (cell_data[k+1]),
			.dn_ready (cell_ready[k+1])
		);
	end

	med3_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (cell_valid[NC]),
		.up_data    (cell_data[NC]),
		.up_ready   (cell_ready[NC]),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.col_out    (col_out),
		.row_out    (row_out),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.frame_done (frame_done)
	);

	`ASSERT_NEXT(a_accept_fills_s1, in_fire, valid_s1, "accepted item missing from stage 1")
	`ASSERT_NEXT(a_col_wrap, in_fire && x_last, col_q == '0, "column counter did not wrap at row end")
	`ASSERT_IMPL(a_stall_hold_s1, valid_s1 && !cell_ready[0], in_stall, "input taken while stage 1 is blocked")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import med3_pkg::*;

	localparam int LIMIT_CYCLES  = 300000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic [COL_OUT_W-1:0] col;
		logic [ROW_W-1:0]     row;
		logic [CH_W-1:0]      red;
		logic [CH_W-1:0]      green;
		logic [CH_W-1:0]      blue;
		logic                 done;
	} px_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_LINE_WIDTH;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [CH_W-1:0]      red_in    = '0;
	logic [CH_W-1:0]      green_in  = '0;
	logic [CH_W-1:0]      blue_in   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [COL_OUT_W-1:0] col_out;
	logic [ROW_W-1:0]     row_out;
	logic [CH_W-1:0]      red_out;
	logic [CH_W-1:0]      green_out;
	logic [CH_W-1:0]      blue_out;
	logic                 frame_done;

	median3x3_red_keyed_filter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.col_out    (col_out),
		.row_out    (row_out),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.frame_done (frame_done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// filter state mirrored on the testbench side
	pix_t             older_row [MAX_LINE_DEF];
	pix_t             newer_row [MAX_LINE_DEF];
	pix_t             win [6];
	int unsigned      frame_col  = 0;
	int unsigned      frame_row  = 0;
	logic [CFG_W-1:0] cfg_width  = LINE_WIDTH_RST;
	logic [CFG_W-1:0] cfg_height = FRAME_HEIGHT_RST;
	px_result_t       pending_px [$];

	int unsigned errors        = 0;
	int unsigned items_sent    = 0;
	int unsigned cycles        = 0;
	int unsigned send_idle_pct = 14;
	int unsigned recv_idle_pct = 74;
	logic        hold_req      = 1'b0;
	logic        hold_ack      = 1'b0;
	int unsigned hold_left     = 0;

	initial begin
		for (int i = 0; i < 6; i++)
			win[i] = '0;
	end

	// exchange sort on red over the whole neighborhood, then take the middle entry
	function automatic pix_t median_by_red(input win_t nb);
		win_t v;
		pix_t t;
		v = nb;
		for (int i = 0; i < NB; i++)
			for (int j = i + 1; j < NB; j++)
				if (v[i][PIX_W-1 -: CH_W] > v[j][PIX_W-1 -: CH_W]) begin
					t = v[i];
					v[i] = v[j];
					v[j] = t;
				end
		return v[MID];
	endfunction

	function automatic void queue_result(input int unsigned col, input int unsigned row,
			input pix_t px, input logic done);
		px_result_t r;
		r.col   = COL_OUT_W'(col);
		r.row   = ROW_W'(row);
		r.red   = px[23:16];
		r.green = px[15:8];
		r.blue  = px[7:0];
		r.done  = done;
		pending_px.push_back(r);
	endfunction

	// advance the mirrored filter by one pixel and queue what it emits
	function automatic void filter_pixel(input pix_t px);
		int unsigned w, h, x, y;
		pix_t up2, up1, c;
		win_t nb;
		w = cfg_width;
		if (w < MIN_DIM) w = MIN_DIM;
		if (w > MAX_LINE_DEF) w = MAX_LINE_DEF;
		h = cfg_height;
		if (h < MIN_DIM) h = MIN_DIM;
		x = (frame_col > w - 1) ? w - 1 : frame_col;
		y = (frame_row > h - 1) ? h - 1 : frame_row;
		up2 = older_row[x];
		up1 = newer_row[x];

		if (y >= 2 && x >= 1) begin
			if (x >= 2) begin
				nb[0] = win[0]; nb[1] = win[1]; nb[2] = up2;
				nb[3] = win[2]; nb[4] = win[3]; nb[5] = up1;
				nb[6] = win[4]; nb[7] = win[5]; nb[8] = px;
				c = median_by_red(nb);
			end else begin
				c = win[3];
			end
			queue_result(x - 1, y - 1, c, 1'b0);
		end
		if (y >= 2 && x == w - 1)
			queue_result(x, y - 1, up1, 1'b0);
		if (y == 0 || y == h - 1)
			queue_result(x, y, px, (x == w - 1 && y == h - 1));

		older_row[x] = up1;
		newer_row[x] = px;
		win[0] = win[1];
		win[1] = up2;
		win[2] = win[3];
		win[3] = up1;
		win[4] = win[5];
		win[5] = px;

		if (x == w - 1) begin
			frame_col = 0;
			frame_row = (y == h - 1) ? 0 : y + 1;
		end else begin
			frame_col = x + 1;
			frame_row = y;
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got, input px_result_t ref_px);
		if (want != got) begin
			$display("%0t: %s at col %0d row %0d: expected %0d, got %0d",
				$time, name, ref_px.col, ref_px.row, want, got);
			errors++;
		end
	endfunction

	// compare each accepted result with the oldest pending one
	always @(posedge clk) begin
		px_result_t got, want;
		if (out_valid && !out_stall) begin
			got = {col_out, row_out, red_out, green_out, blue_out, frame_done};
			if (pending_px.size() == 0) begin
				$display("%0t: unexpected result col %0d row %0d rgb %h %h %h done %b",
					$time, col_out, row_out, red_out, green_out, blue_out, frame_done);
				errors++;
			end else begin
				want = pending_px.pop_front();
				check_field("col", want.col, got.col, want);
				check_field("row", want.row, got.row, want);
				check_field("red", want.red, got.red, want);
				check_field("green", want.green, got.green, want);
				check_field("blue", want.blue, got.blue, want);
				check_field("frame_done", want.done, got.done, want);
			end
		end
	end

	// drive the receiver stall: a long hold on request, else random
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results pending", $time, pending_px.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// offer one pixel, hold it until accepted, then predict its results
	task automatic send_pixel(input pix_t px);
		int unsigned gap;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{red_in, green_in, blue_in} <= px;
		do @(posedge clk); while (in_stall);
		filter_pixel(px);
		items_sent++;
	endtask

	// drop valid, wait out pending results and the pipeline tail
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LINE_WIDTH)
			cfg_width = val;
		else
			cfg_height = val;
		@(posedge clk);
	endtask

	// random color, red often saturated or tied so sort order matters
	function automatic pix_t rand_pixel();
		logic [CH_W-1:0] r, g, b;
		r = CH_W'($urandom);
		g = CH_W'($urandom);
		b = CH_W'($urandom);
		case ($urandom_range(3))
			0: r = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
			1: r = 8'd100 + CH_W'($urandom_range(2));
			default: ;
		endcase
		return {r, g, b};
	endfunction

	// one whole frame at the given geometry, optionally shrunk partway through
	task automatic run_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input bit shrink);
		int unsigned ew, eh, cut, n;
		wait_idle();
		write_reg(REG_LINE_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		ew = (w < MIN_DIM) ? MIN_DIM : ((w > MAX_LINE_DEF) ? MAX_LINE_DEF : w);
		eh = (h < MIN_DIM) ? MIN_DIM : h;
		cut = shrink ? $urandom_range(1, ew * eh - 1) : 0;
		n = 0;
		do begin
			send_pixel(rand_pixel());
			n++;
			// only shrink mid-frame: growing would read line entries never written
			if (n == cut) begin
				wait_idle();
				if ($urandom_range(1) != 0)
					write_reg(REG_LINE_WIDTH, CFG_W'($urandom_range(0, ew)));
				else
					write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, eh)));
			end
		end while (frame_col != 0 || frame_row != 0);
	endtask

	// reset geometry, then cut the row and the frame short with undersized values
	task automatic test_reset_geometry();
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
		send_pixel(24'hAA55AA);
		send_pixel(24'h55AA55);
		send_pixel(24'h807F01);
		wait_idle();
		// width below minimum acts as three, so the pixel at column five is clamped to column two and closes the row
		write_reg(REG_LINE_WIDTH, 12'd2);
		send_pixel(24'h0180FE);
		// equal reds in the middle row check which tied entry lands in the middle
		send_pixel(24'h401020);
		send_pixel(24'h403040);
		send_pixel(24'h405060);
		wait_idle();
		write_reg(REG_FRAME_HEIGHT, 12'd0);
		send_pixel(24'h40AA00);
		send_pixel(24'h3FFFFF);
		send_pixel(24'h41FF00);
	endtask

	// widest line and tallest frame, then trim both to end the frame quickly
	task automatic test_max_geometry();
		wait_idle();
		write_reg(REG_LINE_WIDTH, 12'd2048);
		write_reg(REG_FRAME_HEIGHT, 12'd4095);
		send_pixel(24'hFF0000);
		send_pixel(24'h00FF00);
		send_pixel(24'h0000FF);
		wait_idle();
		// above the line limit, same effective width
		write_reg(REG_LINE_WIDTH, 12'd4095);
		send_pixel(24'h7F7F7F);
		wait_idle();
		write_reg(REG_LINE_WIDTH, 12'd4);
		send_pixel(24'hC3C3C3);
		repeat (4) send_pixel(rand_pixel());
		wait_idle();
		write_reg(REG_FRAME_HEIGHT, 12'd3);
		repeat (4) send_pixel(rand_pixel());
	endtask

	task automatic test_random_frames(input int unsigned send_pct, input int unsigned recv_pct,
			input int unsigned quota);
		int unsigned first, w, h;
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
		first = items_sent;
		while (items_sent - first < quota) begin
			case ($urandom_range(7))
				0: w = $urandom_range(0, 2);
				1: w = $urandom_range(16, 24);
				default: w = $urandom_range(3, 10);
			endcase
			h = ($urandom_range(3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
			// keep wide frames short
			if (w > 12) h = 3;
			run_frame(CFG_W'(w), CFG_W'(h), $urandom_range(3) == 0);
		end
	endtask

	// hold the output for a long stretch while pixels keep coming
	task automatic test_output_hold();
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		wait_idle();
		hold_req <= !hold_req;
		run_frame(12'd8, 12'd5, 1'b0);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_max_geometry();
		test_random_frames(14, 74, 65);
		test_random_frames(74, 14, 65);
		test_output_hold();
		test_random_frames(0, 0, 65);
		wait_idle();
		if (errors == 0 && pending_px.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
